FILE: hdl/sdpg_pkg.sv
// Shared types, constants and codes for the step/direction pulse generator.
package sdpg_pkg;

  // Block sizing.
  localparam int NUM_AXES     = 4;
  localparam int TICK_RATE_HZ = 1000000;
  localparam int MAX_STEP_HZ  = 10000;
  localparam int DUTY_DIV     = 100;

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int AXIS_W   = 3;
  localparam int FREQ_W   = 16;
  localparam int POS_W    = 32;
  localparam int STAT_W   = 2;
  localparam int DUTY_W   = 7;
  localparam int AXCNT_W  = 3;
  localparam int AX_W     = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int PER_W    = $clog2(TICK_RATE_HZ + 1);
  localparam int PROD_W   = PER_W + DUTY_W;
  localparam int DIV_W    = PROD_W;
  localparam int DCNT_W   = $clog2(DIV_W);

  // Stream payload widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_AXES_IN_USE = 1'b0;
  localparam logic REG_DUTY        = 1'b1;
  localparam logic [AXCNT_W-1:0] AXES_RESET = AXCNT_W'(4);
  localparam logic [DUTY_W-1:0]  DUTY_RESET = DUTY_W'(50);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SETFREQ = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READPOS = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ARG = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ST  = 2'd2;

  // Axis operating mode.
  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_ENABLED  = 2'd1,
    MODE_MOVING   = 2'd2
  } mode_t;

  // Request to the serial divider.
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: hdl/sdpg_div.sv
// Restoring divider that produces one quotient bit per cycle.
module sdpg_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sdpg_pkg::div_req_t       req,
  output logic                     done,
  output logic [sdpg_pkg::DIV_W-1:0] quot
);

  logic [sdpg_pkg::DIV_W-1:0]  dvd_r;
  logic [sdpg_pkg::FREQ_W-1:0] rem_r;
  logic [sdpg_pkg::FREQ_W-1:0] dvs_r;
  logic [sdpg_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [sdpg_pkg::FREQ_W:0]   rem_sh;
  logic                        fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign rem_sh = {rem_r, dvd_r[sdpg_pkg::DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  // Control: busy for DIV_W steps, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == sdpg_pkg::DCNT_W'(sdpg_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: the dividend register collects quotient bits as it shifts out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[sdpg_pkg::DIV_W-2:0], fits};
      if (fits) begin
        rem_r <= sdpg_pkg::FREQ_W'(rem_sh - {1'b0, dvs_r});
      end else begin
        rem_r <= rem_sh[sdpg_pkg::FREQ_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

`ifndef ASSERT_OFF
  // The done pulse follows the last step of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  // A new request never lands on a running division.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("divider restarted while busy");
  // The partial remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");
`endif

endmodule

FILE: hdl/step_dir_pulse_generator.sv
// Top level of the multi-axis step/direction pulse generator.
// Sequence: a request that arms no pulse passes EXEC and RES, then raises out_tvalid from the output register.
// A request that arms a pulse also passes DIV1, MUL, DIV2 and ARM: two passes of the bit-serial divider,
// 27 steps each (period from the tick rate, then high time from the duty product).
// Requests are taken one at a time, only in IDLE, after the last one has left RES; the output
// register lets the next request enter while a result waits.
// Reset (synchronous, rst_n low) disables all axes, clears positions and pulses, restores registers.
module step_dir_pulse_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: axis[2:0], direction_forward[3], frequency[19:4], zero[23:20]
  input  logic [sdpg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: kind[2:0]
  input  logic [sdpg_pkg::KIND_W-1:0]        in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: status[1:0], step_out[2], dir_forward[3], drive_enabled[4], moving[5],
  //            position[37:6], zero[39:38]
  output logic [sdpg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sdpg_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [sdpg_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [sdpg_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_DIV1 = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DIV2 = 7'b0010000,
    ST_RES  = 7'b0100000,
    ST_ARM  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [sdpg_pkg::AXCNT_W-1:0] axes_r;
  logic [sdpg_pkg::DUTY_W-1:0]  duty_r;

  // Captured request.
  logic [sdpg_pkg::KIND_W-1:0]  it_kind_r;
  logic [sdpg_pkg::AXIS_W-1:0]  it_axis_r;
  logic                         it_fwd_r;
  logic [sdpg_pkg::FREQ_W-1:0]  it_freq_r;
  logic [sdpg_pkg::STAT_W-1:0]  it_stat_r;
  logic                         it_bad_r;

  // Per-axis state.
  sdpg_pkg::mode_t              ax_mode_r [sdpg_pkg::NUM_AXES];
  logic                         ax_dir_r  [sdpg_pkg::NUM_AXES];
  logic [sdpg_pkg::FREQ_W-1:0]  ax_freq_r [sdpg_pkg::NUM_AXES];
  logic [sdpg_pkg::POS_W-1:0]   ax_pos_r  [sdpg_pkg::NUM_AXES];
  logic                         pl_act_r  [sdpg_pkg::NUM_AXES];
  logic [sdpg_pkg::PER_W-1:0]   pl_cnt_r  [sdpg_pkg::NUM_AXES];
  logic [sdpg_pkg::PER_W-1:0]   pl_per_r  [sdpg_pkg::NUM_AXES];
  logic [sdpg_pkg::PER_W-1:0]   pl_high_r [sdpg_pkg::NUM_AXES];

  // Pulse timing work registers.
  logic [sdpg_pkg::PER_W-1:0]   per_r;
  logic [sdpg_pkg::PER_W-1:0]   high_r;

  // Output register.
  logic                             out_valid_r;
  logic [sdpg_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [sdpg_pkg::AX_W-1:0]    idx;
  logic                         bad_c;
  logic                         cfg_wr;
  logic [sdpg_pkg::PER_W-1:0]   cnt_inc;
  logic                         pulse_end;
  logic                         arm_c;
  logic [sdpg_pkg::FREQ_W-1:0]  f_arm;
  logic [sdpg_pkg::PROD_W-1:0]  prod_c;
  logic [sdpg_pkg::PER_W-1:0]   per_c;
  logic [sdpg_pkg::PER_W-1:0]   high_c;
  logic                         res_free;
  logic                         step_c;
  sdpg_pkg::div_req_t           div_req;
  logic                         div_done;
  logic [sdpg_pkg::DIV_W-1:0]   div_quot;

  sdpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration port: writes complete in the access cycle, reads are direct.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (cfg_paddr[2] == sdpg_pkg::REG_AXES_IN_USE) begin
      cfg_prdata = sdpg_pkg::CFG_DW'(axes_r);
    end else begin
      cfg_prdata = sdpg_pkg::CFG_DW'(duty_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axes_r <= sdpg_pkg::AXES_RESET;
      duty_r <= sdpg_pkg::DUTY_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == sdpg_pkg::REG_AXES_IN_USE) begin
        axes_r <= cfg_pwdata[sdpg_pkg::AXCNT_W-1:0];
      end else begin
        duty_r <= cfg_pwdata[sdpg_pkg::DUTY_W-1:0];
      end
    end
  end

  // Addressed axis and its range check.
  assign idx   = it_axis_r[sdpg_pkg::AX_W-1:0];
  assign bad_c = (it_axis_r >= axes_r) ||
                 ({1'b0, it_axis_r} >= (sdpg_pkg::AXIS_W + 1)'(sdpg_pkg::NUM_AXES));

  // Tick bookkeeping and the decision to arm a new pulse.
  assign cnt_inc   = pl_cnt_r[idx] + 1'b1;
  assign pulse_end = pl_act_r[idx] && (cnt_inc >= pl_per_r[idx]);

  always_comb begin
    arm_c = 1'b0;
    f_arm = ax_freq_r[idx];
    if (!bad_c) begin
      if (it_kind_r == sdpg_pkg::KIND_TICK) begin
        arm_c = pulse_end && (ax_mode_r[idx] == sdpg_pkg::MODE_MOVING) &&
                (ax_freq_r[idx] != '0);
      end else if (it_kind_r == sdpg_pkg::KIND_START) begin
        arm_c = (ax_mode_r[idx] == sdpg_pkg::MODE_ENABLED) && !pl_act_r[idx];
        if (ax_freq_r[idx] == '0) begin
          f_arm = sdpg_pkg::FREQ_W'(sdpg_pkg::MAX_STEP_HZ);
        end
      end
    end
    if (f_arm == '0) begin
      f_arm = sdpg_pkg::FREQ_W'(1);
    end
  end

  // Period clamp, duty product and high-time clamp.
  always_comb begin
    per_c = div_quot[sdpg_pkg::PER_W-1:0];
    if (per_c < sdpg_pkg::PER_W'(2)) begin
      per_c = sdpg_pkg::PER_W'(2);
    end
  end

  assign prod_c = sdpg_pkg::PROD_W'(per_r) * sdpg_pkg::PROD_W'(duty_r);

  always_comb begin
    if (div_quot == '0) begin
      high_c = sdpg_pkg::PER_W'(1);
    end else if (div_quot >= sdpg_pkg::DIV_W'(per_r)) begin
      high_c = per_r - 1'b1;
    end else begin
      high_c = div_quot[sdpg_pkg::PER_W-1:0];
    end
  end

  // Divider requests: period first, then high time.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = sdpg_pkg::DIV_W'(sdpg_pkg::TICK_RATE_HZ);
    div_req.divisor  = f_arm;
    if (state_r == ST_EXEC) begin
      div_req.start = arm_c;
    end else if (state_r == ST_MUL) begin
      div_req.start    = 1'b1;
      div_req.dividend = prod_c;
      div_req.divisor  = sdpg_pkg::FREQ_W'(sdpg_pkg::DUTY_DIV);
    end
  end

  // Handshakes.
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign res_free   = !out_valid_r || out_tready;
  assign step_c     = pl_act_r[idx] && (pl_cnt_r[idx] < pl_high_r[idx]);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = arm_c ? ST_DIV1 : ST_RES;
      ST_DIV1: if (div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV2;
      ST_DIV2: if (div_done) state_nxt = ST_ARM;
      ST_ARM:  state_nxt = ST_RES;
      ST_RES:  if (res_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      it_kind_r <= in_tuser;
      it_axis_r <= in_tdata[2:0];
      it_fwd_r  <= in_tdata[3];
      it_freq_r <= in_tdata[19:4];
    end
  end

  // Pulse timing work registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV1 && div_done) begin
      per_r <= per_c;
    end
    if (state_r == ST_DIV2 && div_done) begin
      high_r <= high_c;
    end
  end

  // Per-axis state update: command effects in EXEC, pulse arming in ARM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sdpg_pkg::NUM_AXES; i++) begin
        ax_mode_r[i] <= sdpg_pkg::MODE_DISABLED;
        ax_dir_r[i]  <= 1'b1;
        ax_freq_r[i] <= '0;
        ax_pos_r[i]  <= '0;
        pl_act_r[i]  <= 1'b0;
        pl_cnt_r[i]  <= '0;
        pl_per_r[i]  <= '0;
        pl_high_r[i] <= '0;
      end
      it_stat_r <= sdpg_pkg::STAT_OK;
      it_bad_r  <= 1'b0;
    end else if (state_r == ST_EXEC) begin
      it_bad_r  <= bad_c;
      it_stat_r <= sdpg_pkg::STAT_OK;
      if (bad_c) begin
        it_stat_r <= sdpg_pkg::STAT_BAD_ARG;
      end else begin
        case (it_kind_r)
          sdpg_pkg::KIND_TICK: begin
            if (pl_act_r[idx]) begin
              if (pulse_end) begin
                if (ax_dir_r[idx]) begin
                  ax_pos_r[idx] <= ax_pos_r[idx] + 1'b1;
                end else begin
                  ax_pos_r[idx] <= ax_pos_r[idx] - 1'b1;
                end
                pl_act_r[idx] <= 1'b0;
                pl_cnt_r[idx] <= '0;
              end else begin
                pl_cnt_r[idx] <= cnt_inc;
              end
            end
          end
          sdpg_pkg::KIND_ENABLE:  ax_mode_r[idx] <= sdpg_pkg::MODE_ENABLED;
          sdpg_pkg::KIND_DISABLE: ax_mode_r[idx] <= sdpg_pkg::MODE_DISABLED;
          sdpg_pkg::KIND_START: begin
            if (ax_mode_r[idx] == sdpg_pkg::MODE_DISABLED) begin
              it_stat_r <= sdpg_pkg::STAT_BAD_ST;
            end else if (ax_mode_r[idx] == sdpg_pkg::MODE_MOVING) begin
              ax_dir_r[idx] <= it_fwd_r;
            end else begin
              ax_dir_r[idx]  <= it_fwd_r;
              ax_freq_r[idx] <= f_arm;
              ax_mode_r[idx] <= sdpg_pkg::MODE_MOVING;
            end
          end
          sdpg_pkg::KIND_STOP: begin
            if (ax_mode_r[idx] == sdpg_pkg::MODE_MOVING) begin
              ax_mode_r[idx] <= sdpg_pkg::MODE_ENABLED;
            end
          end
          sdpg_pkg::KIND_SETFREQ: begin
            if (it_freq_r > sdpg_pkg::FREQ_W'(sdpg_pkg::MAX_STEP_HZ)) begin
              it_stat_r <= sdpg_pkg::STAT_BAD_ARG;
            end else begin
              ax_freq_r[idx] <= it_freq_r;
            end
          end
          sdpg_pkg::KIND_READPOS: it_stat_r <= sdpg_pkg::STAT_OK;
          default: it_stat_r <= sdpg_pkg::STAT_BAD_ARG;
        endcase
      end
    end else if (state_r == ST_ARM) begin
      pl_per_r[idx]  <= per_r;
      pl_high_r[idx] <= high_r;
      pl_cnt_r[idx]  <= '0;
      pl_act_r[idx]  <= 1'b1;
    end
  end

  // Output register: loaded from the finished request, held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RES && res_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RES && res_free) begin
      if (it_bad_r) begin
        out_data_r <= sdpg_pkg::OUT_TDATA_W'(it_stat_r);
      end else begin
        out_data_r <= {2'b00, ax_pos_r[idx],
                       (ax_mode_r[idx] == sdpg_pkg::MODE_MOVING),
                       (ax_mode_r[idx] != sdpg_pkg::MODE_DISABLED),
                       ax_dir_r[idx], step_c, it_stat_r};
      end
    end
  end

`ifndef ASSERT_OFF
  // An accepted request always goes straight to execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_EXEC))
    else $error("accepted request did not enter execution");
  // Divider results only arrive while the sequencer waits for them.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV1 || state_r == ST_DIV2))
    else $error("divider finished outside a divide state");
  // An armed pulse always has a high time inside its period.
  a_high_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && pl_act_r[idx]) |->
      (pl_high_r[idx] != '0 && pl_high_r[idx] < pl_per_r[idx]))
    else $error("pulse high time outside its period");
  // A finished request is presented on the next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && res_free) |=> out_valid_r)
    else $error("result not loaded into the output register");
`endif

endmodule
